### sv/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// shared types, phrase tables and result codes of the failure phrase classifier
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

    localparam int WINDOW_BYTES_DEF = 38;
    localparam int PHRASE_COUNT     = 14;
    localparam int PHRASE_MAX       = 38;
    localparam int GROUP_COUNT      = 4;
    localparam int PLEN_W           = $clog2(PHRASE_MAX + 1);

    typedef logic [7:0]                  t_byte;
    typedef logic [PHRASE_MAX*8-1:0]     t_phrase;
    typedef logic [PLEN_W-1:0]           t_plen;
    // byte j of the tail sits j places behind the newest byte
    typedef logic [PHRASE_MAX-1:0][7:0]  t_tail;
    typedef logic [GROUP_COUNT-1:0]      t_groups;

    typedef enum logic [1:0] {
        GRP_HOST_KEY = 2'd0,
        GRP_UNREACH  = 2'd1,
        GRP_CONN     = 2'd2,
        GRP_AUTH     = 2'd3
    } t_group;

    typedef enum logic [2:0] {
        CLS_NONE     = 3'd0,
        CLS_HOST_KEY = 3'd1,
        CLS_UNREACH  = 3'd2,
        CLS_CONN     = 3'd3,
        CLS_AUTH     = 3'd4
    } t_class;

    // per-cell control, common to the whole row
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // string literals are right aligned, so the last character lands in bits [7:0]
    localparam t_phrase PHRASE_TEXT [PHRASE_COUNT] = '{
        "host key verification failed",
        "remote host identification has changed",
        "could not resolve hostname",
        "name or service not known",
        "temporary failure in name resolution",
        "connection refused",
        "connection timed out",
        "no route to host",
        "operation not permitted",
        "connection reset",
        "connection closed",
        "permission denied",
        "authentication failed",
        "no more authentication methods"
    };

    localparam t_plen PHRASE_LEN [PHRASE_COUNT] = '{
        t_plen'(28), t_plen'(38), t_plen'(26), t_plen'(25), t_plen'(36),
        t_plen'(18), t_plen'(20), t_plen'(16), t_plen'(23), t_plen'(16),
        t_plen'(17), t_plen'(17), t_plen'(21), t_plen'(30)
    };

    localparam t_group PHRASE_GROUP [PHRASE_COUNT] = '{
        GRP_HOST_KEY, GRP_HOST_KEY,
        GRP_UNREACH,  GRP_UNREACH,  GRP_UNREACH,
        GRP_CONN,     GRP_CONN,     GRP_CONN,     GRP_CONN,     GRP_CONN,     GRP_CONN,
        GRP_AUTH,     GRP_AUTH,     GRP_AUTH
    };

endpackage

`default_nettype wire

### sv/fpc_if.sv
// ----------------------------------------------------------------------------
// fpc_if
// valid/ready channels for text bytes and classification results
// ----------------------------------------------------------------------------
`default_nettype none

interface fpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface fpc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] failure_class;
    logic       auth_seen;
    logic       host_key_seen;

    modport source (output valid, output failure_class, output auth_seen,
                    output host_key_seen, input ready);
    modport sink   (input valid, input failure_class, input auth_seen,
                    input host_key_seen, output ready);
endinterface

`default_nettype wire

### sv/fpc_cell.sv
// ----------------------------------------------------------------------------
// fpc_cell
// one byte of the recent-text window, passed to its older neighbour on a shift
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fpc_pkg::t_cell_ctl i_ctl,
    input  wire fpc_pkg::t_byte    i_byte,
    output fpc_pkg::t_byte         o_byte
);
    import fpc_pkg::*;

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_byte <= '0;
        end else if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

### sv/fpc_match.sv
// ----------------------------------------------------------------------------
// fpc_match
// compares the window tail with every phrase at once, one hit bit per group
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_match (
    input  wire fpc_pkg::t_tail i_tail,
    output fpc_pkg::t_groups    o_hit
);
    import fpc_pkg::*;

    always_comb begin
        logic v_ok;
        o_hit = '0;
        for (int p = 0; p < PHRASE_COUNT; p++) begin
            v_ok = 1'b1;
            for (int j = 0; j < PHRASE_MAX; j++) begin
                if ((j < int'(PHRASE_LEN[p])) && (i_tail[j] != PHRASE_TEXT[p][8*j +: 8])) begin
                    v_ok = 1'b0;
                end
            end
            if (v_ok) begin
                o_hit[PHRASE_GROUP[p]] = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### sv/failure_phrase_classifier_top.sv
// ----------------------------------------------------------------------------
// failure_phrase_classifier_top
// streaming classifier of remote-login error texts by fixed phrases
// ----------------------------------------------------------------------------
// The block takes one text byte per transfer, folds A-Z to lower case and
// shifts it into a row of WINDOW_BYTES byte cells. In the same cycle the
// newest bytes of the window are compared against fourteen fixed phrases in
// four groups (host key, unreachable, connection, authentication), and a
// match sets a sticky group flag. The byte marked end_of_text produces one
// result transfer: the highest-priority group seen (host key first, then
// unreachable, connection, authentication, else none) plus separate auth and
// host-key flags; the window and flags are then cleared for the next text.
// Bytes without end_of_text produce no result. Throughput is one byte per
// clock: each byte is compared while it is being shifted in, and the
// result sits in an output register, so input is taken even while a result
// waits, and stops only when that register is full and not being drained.
// A result appears in the cycle after its last byte is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module failure_phrase_classifier_top #(
    parameter int WINDOW_BYTES = fpc_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fpc_in_if.sink      i_text,
    fpc_out_if.source   o_result
);
    import fpc_pkg::*;

    // window cells, index WINDOW_BYTES-1 holds the newest byte
    t_byte     w_cell_d [WINDOW_BYTES];
    t_byte     w_cell_q [WINDOW_BYTES];
    t_tail     w_tail;
    t_groups   w_hit;
    t_groups   w_found;
    t_cell_ctl w_ctl;
    t_byte     w_folded;
    t_class    w_class;
    logic      w_accept;

    t_groups r_found;
    t_groups n_found;
    logic    r_out_valid;
    logic    n_out_valid;
    t_class  r_class;
    logic    r_auth;
    logic    r_host;

    // input stalls only when a result is held and not taken this cycle
    assign i_text.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_text.valid && i_text.ready;

    // case fold on upper-case letters only
    always_comb begin
        if (i_text.text_byte >= 8'h41 && i_text.text_byte <= 8'h5A) begin
            w_folded = i_text.text_byte + 8'd32;
        end else begin
            w_folded = i_text.text_byte;
        end
    end

    // a final byte clears the row instead of shifting
    assign w_ctl.shift = w_accept && !i_text.end_of_text;
    assign w_ctl.clear = w_accept && i_text.end_of_text;

    genvar k;
    generate
        for (k = 0; k < WINDOW_BYTES; k++) begin : g_cell
            if (k == WINDOW_BYTES - 1) begin : g_head
                assign w_cell_d[k] = w_folded;
            end else begin : g_link
                assign w_cell_d[k] = w_cell_q[k+1];
            end
            fpc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_byte  (w_cell_d[k]),
                .o_byte  (w_cell_q[k])
            );
        end
        // compare the shifted window, including the byte in transfer
        for (k = 0; k < PHRASE_MAX; k++) begin : g_tail
            assign w_tail[k] = w_cell_d[WINDOW_BYTES-1-k];
        end
    endgenerate

    fpc_match u_match (
        .i_tail (w_tail),
        .o_hit  (w_hit)
    );

    assign w_found = r_found | w_hit;

    // priority: host key, unreachable, connection, authentication
    always_comb begin
        if (w_found[GRP_HOST_KEY]) begin
            w_class = CLS_HOST_KEY;
        end else if (w_found[GRP_UNREACH]) begin
            w_class = CLS_UNREACH;
        end else if (w_found[GRP_CONN]) begin
            w_class = CLS_CONN;
        end else if (w_found[GRP_AUTH]) begin
            w_class = CLS_AUTH;
        end else begin
            w_class = CLS_NONE;
        end
    end

    always_comb begin
        n_found = r_found;
        if (w_ctl.clear) begin
            n_found = '0;
        end else if (w_ctl.shift) begin
            n_found = w_found;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctl.clear) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded with the final byte of each text
    always_ff @(posedge i_clk) begin
        if (w_ctl.clear) begin
            r_class <= w_class;
            r_auth  <= w_found[GRP_AUTH];
            r_host  <= w_found[GRP_HOST_KEY];
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.failure_class = r_class;
    assign o_result.auth_seen     = r_auth;
    assign o_result.host_key_seen = r_host;

endmodule

`default_nettype wire

### sv/fpc_checker.sv
// ----------------------------------------------------------------------------
// fpc_checker
// port-level checks of the failure phrase classifier, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_end,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_out_class,
    input wire logic       i_out_auth,
    input wire logic       i_out_host
);
    import fpc_pkg::*;

    // held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_class)
            && $stable(i_out_auth) && $stable(i_out_host))
        else $error("result changed while stalled");

    // a final byte always gives a result next cycle
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_end |=> i_out_valid)
        else $error("final byte produced no result");

    // host key outranks every other group
    a_host_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_host |-> i_out_class == CLS_HOST_KEY)
        else $error("host key flag without host key class");

    a_class_host: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_class == CLS_HOST_KEY |-> i_out_host)
        else $error("host key class without host key flag");

    // an auth phrase rules out the none class
    a_auth_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_auth |-> i_out_class != CLS_NONE)
        else $error("auth flag with none class");

endmodule

bind failure_phrase_classifier_top fpc_checker u_fpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_text.valid),
    .i_in_ready  (i_text.ready),
    .i_in_end    (i_text.end_of_text),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_class (o_result.failure_class),
    .i_out_auth  (o_result.auth_seen),
    .i_out_host  (o_result.host_key_seen)
);

`default_nettype wire
